/* rtl/sus_pkg.sv */
// shared types and constants for the shortest unsorted span block
// no dependencies; used by every other file of the block
`default_nettype none
package sus_pkg;

	localparam int DATA_W = 32;
	localparam int SPAN_W = 11;

	typedef enum logic [3:0] {
		ST_LOAD,
		ST_PRE_ISSUE,
		ST_PRE_EVAL,
		ST_SUF_ISSUE,
		ST_SUF_EVAL,
		ST_MM_ISSUE,
		ST_MM_EVAL,
		ST_LEFT_ISSUE,
		ST_LEFT_EVAL,
		ST_RIGHT_ISSUE,
		ST_RIGHT_EVAL,
		ST_FINISH
	} sus_state_t;

	typedef struct packed {
		logic [SPAN_W-1:0] span_length;
		logic              overflow;
	} sus_result_t;

endpackage
`default_nettype wire

/* rtl/sus_in_if.sv */
// input channel of the shortest unsorted span block: one sequence element per transaction
// depends on sus_pkg for the data width
`default_nettype none
interface sus_in_if;
	logic                             valid;
	logic                             ready;
	logic signed [sus_pkg::DATA_W-1:0] value;
	logic                             last;

	modport source (output valid, output value, output last, input ready);
	modport sink (input valid, input value, input last, output ready);
endinterface
`default_nettype wire

/* rtl/sus_out_if.sv */
// result channel of the shortest unsorted span block: one result per sequence
// depends on sus_pkg for the span width
`default_nettype none
interface sus_out_if;
	logic                       valid;
	logic                       ready;
	logic [sus_pkg::SPAN_W-1:0] span_length;
	logic                       overflow;

	modport source (output valid, output span_length, output overflow, input ready);
	modport sink (input valid, input span_length, input overflow, output ready);
endinterface
`default_nettype wire

/* rtl/shortest_unsorted_span_core.sv */
// top level of the shortest unsorted span block
// depends on sus_pkg, sus_in_if, sus_out_if, sus_mem, sus_scan
`default_nettype none
// Elements of a sequence enter one per transaction on items and are written
// to a single-port-write, single-port-read element memory of MAX_ELEMENTS
// entries; the input stays ready while loading. Elements past the memory
// depth are dropped and reported through overflow. When the transaction
// marked last is taken, the input stalls while a sequencer walks the stored
// elements through the one memory read port, one element per cycle: the
// non-decreasing prefix, the non-decreasing suffix, minimum and maximum of
// the middle span, then the outward widening to the left and right. Each
// walk opens with an issue state that reads its first element and goes on
// in an evaluate state that reads the rest, so the scan is bounded by
// the single read port of the element memory. The result, the length of
// the shortest span whose sorting sorts everything (0 if already sorted),
// goes to an output register on results; loading of the next sequence may
// start while it waits to be taken. The memory has no reset and needs no
// clearing pass, since only entries of the current sequence are ever used.
module shortest_unsorted_span_core #(
	parameter int MAX_ELEMENTS = 1024
) (
	input  wire logic clk,
	input  wire logic arst_n,
	sus_in_if.sink    items,
	sus_out_if.source results
);

	// count holds 0..MAX_ELEMENTS, address holds 0..MAX_ELEMENTS-1
	localparam int CW = $clog2(MAX_ELEMENTS + 1);
	localparam int AW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;

	logic                              wr_en;
	logic [AW-1:0]                     wr_addr;
	logic signed [sus_pkg::DATA_W-1:0] wr_data;
	logic                              rd_en;
	logic [AW-1:0]                     rd_addr;
	logic signed [sus_pkg::DATA_W-1:0] rd_data;
	logic                              res_valid;
	logic                              res_ready;
	sus_pkg::sus_result_t              res;

	// output register
	logic                 out_valid_q;
	sus_pkg::sus_result_t out_q;

	// writes happen only while loading and reads only while scanning,
	// so the two ports never touch the same entry in one cycle
	sus_mem #(
		.DEPTH (MAX_ELEMENTS),
		.AW    (AW)
	) u_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	sus_scan #(
		.MAX_ELEMENTS (MAX_ELEMENTS),
		.AW           (AW),
		.CW           (CW)
	) u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.items     (items),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.rd_data   (rd_data),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	// a new result may enter when the register is empty or being drained
	assign res_ready = !out_valid_q || results.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign results.valid       = out_valid_q;
	assign results.span_length = out_q.span_length;
	assign results.overflow    = out_q.overflow;

endmodule
`default_nettype wire

/* rtl/sus_mem.sv */
// element memory: one write port, one read port, registered read data
// depends on sus_pkg for the data width
`default_nettype none
module sus_mem #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10
) (
	input  wire logic                              clk,
	input  wire logic                              wr_en,
	input  wire logic [AW-1:0]                     wr_addr,
	input  wire logic signed [sus_pkg::DATA_W-1:0] wr_data,
	input  wire logic                              rd_en,
	input  wire logic [AW-1:0]                     rd_addr,
	output logic signed [sus_pkg::DATA_W-1:0]      rd_data
);

	logic signed [sus_pkg::DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule
`default_nettype wire

/* rtl/sus_scan.sv */
// load counter and scan sequencer: fills the element memory, then walks it
// depends on sus_pkg, sus_in_if; drives the ports of sus_mem
`default_nettype none
module sus_scan #(
	parameter int MAX_ELEMENTS = 1024,
	parameter int AW           = 10,
	parameter int CW           = 11
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	sus_in_if.sink                                 items,
	output logic                                   wr_en,
	output logic [AW-1:0]                          wr_addr,
	output logic signed [sus_pkg::DATA_W-1:0]      wr_data,
	output logic                                   rd_en,
	output logic [AW-1:0]                          rd_addr,
	input  wire logic signed [sus_pkg::DATA_W-1:0] rd_data,
	output logic                                   res_valid,
	input  wire logic                              res_ready,
	output sus_pkg::sus_result_t                   res
);

	localparam int IW = CW + 1;
	localparam int LW = (CW > sus_pkg::SPAN_W) ? CW : sus_pkg::SPAN_W;

	sus_pkg::sus_state_t state_q, state_nxt;

	logic [CW-1:0]                     count_q;
	logic                              dropped_q;
	logic [CW-1:0]                     n_q;
	logic                              ovf_q;
	logic                              zero_q;
	logic                              first_q;
	logic signed [IW-1:0]              idx_q;
	logic signed [IW-1:0]              lo_q;
	logic signed [IW-1:0]              hi_q;
	logic signed [sus_pkg::DATA_W-1:0] prev_q;
	logic signed [sus_pkg::DATA_W-1:0] vmin_q;
	logic signed [sus_pkg::DATA_W-1:0] vmax_q;

	logic                 accept;
	logic                 room;
	logic [CW-1:0]        n_new;
	logic signed [IW-1:0] n_s;
	logic signed [IW-1:0] nm1;
	logic signed [IW-1:0] rd_idx;
	logic                 idx_first;
	logic                 idx_end;
	logic                 idx_hi;
	logic                 pre_brk;
	logic                 suf_brk;
	logic                 left_go;
	logic                 right_go;
	logic                 advance;
	logic signed [IW-1:0] span_s;
	logic [LW-1:0]        span_ext;

	assign accept    = items.valid && items.ready;
	assign room      = (count_q < CW'(MAX_ELEMENTS));
	assign n_new     = room ? (count_q + CW'(1)) : count_q;
	assign n_s       = $signed({1'b0, n_q});
	assign nm1       = n_s - IW'(1);
	assign idx_first = (idx_q == IW'(0));
	assign idx_end   = (idx_q == nm1);
	assign idx_hi    = (idx_q == hi_q);
	assign pre_brk   = !first_q && (prev_q > rd_data);
	assign suf_brk   = !first_q && (rd_data > prev_q);
	assign left_go   = (rd_data > vmin_q);
	assign right_go  = (rd_data < vmax_q);

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			sus_pkg::ST_LOAD: begin
				if (accept && items.last) begin
					state_nxt = (n_new > CW'(1)) ? sus_pkg::ST_PRE_ISSUE : sus_pkg::ST_FINISH;
				end
			end
			sus_pkg::ST_PRE_ISSUE:   state_nxt = sus_pkg::ST_PRE_EVAL;
			sus_pkg::ST_PRE_EVAL: begin
				if (pre_brk) begin
					state_nxt = sus_pkg::ST_SUF_ISSUE;
				end else if (!first_q && idx_end) begin
					state_nxt = sus_pkg::ST_FINISH;
				end
			end
			sus_pkg::ST_SUF_ISSUE:   state_nxt = sus_pkg::ST_SUF_EVAL;
			sus_pkg::ST_SUF_EVAL: begin
				if (suf_brk || idx_first) begin
					state_nxt = sus_pkg::ST_MM_ISSUE;
				end
			end
			sus_pkg::ST_MM_ISSUE:    state_nxt = sus_pkg::ST_MM_EVAL;
			sus_pkg::ST_MM_EVAL: begin
				if (idx_hi) begin
					state_nxt = sus_pkg::ST_LEFT_ISSUE;
				end
			end
			sus_pkg::ST_LEFT_ISSUE:  state_nxt = sus_pkg::ST_LEFT_EVAL;
			sus_pkg::ST_LEFT_EVAL: begin
				if (!left_go || idx_first) begin
					state_nxt = sus_pkg::ST_RIGHT_ISSUE;
				end
			end
			sus_pkg::ST_RIGHT_ISSUE: state_nxt = sus_pkg::ST_RIGHT_EVAL;
			sus_pkg::ST_RIGHT_EVAL: begin
				if (!right_go || idx_end) begin
					state_nxt = sus_pkg::ST_FINISH;
				end
			end
			sus_pkg::ST_FINISH: begin
				if (res_ready) begin
					state_nxt = sus_pkg::ST_LOAD;
				end
			end
			default:                 state_nxt = sus_pkg::ST_LOAD;
		endcase
	end

	// outputs: handshake, memory ports, read index
	always_comb begin
		items.ready = 1'b0;
		res_valid   = 1'b0;
		rd_en       = 1'b0;
		rd_idx      = idx_q;
		advance     = 1'b0;
		case (state_q)
			sus_pkg::ST_LOAD:        items.ready = 1'b1;
			sus_pkg::ST_PRE_ISSUE: begin
				rd_en   = 1'b1;
				rd_idx  = '0;
				advance = 1'b1;
			end
			sus_pkg::ST_PRE_EVAL: begin
				rd_en   = 1'b1;
				rd_idx  = idx_q + IW'(1);
				advance = !pre_brk && (first_q || !idx_end);
			end
			sus_pkg::ST_SUF_ISSUE: begin
				rd_en   = 1'b1;
				rd_idx  = nm1;
				advance = 1'b1;
			end
			sus_pkg::ST_SUF_EVAL: begin
				rd_en   = 1'b1;
				rd_idx  = idx_q - IW'(1);
				advance = !suf_brk && !idx_first;
			end
			sus_pkg::ST_MM_ISSUE: begin
				rd_en   = 1'b1;
				rd_idx  = lo_q;
				advance = 1'b1;
			end
			sus_pkg::ST_MM_EVAL: begin
				rd_en   = 1'b1;
				rd_idx  = idx_q + IW'(1);
				advance = !idx_hi;
			end
			sus_pkg::ST_LEFT_ISSUE: begin
				rd_en   = 1'b1;
				rd_idx  = lo_q;
				advance = 1'b1;
			end
			sus_pkg::ST_LEFT_EVAL: begin
				rd_en   = 1'b1;
				rd_idx  = idx_q - IW'(1);
				advance = left_go && !idx_first;
			end
			sus_pkg::ST_RIGHT_ISSUE: begin
				rd_en   = 1'b1;
				rd_idx  = hi_q;
				advance = 1'b1;
			end
			sus_pkg::ST_RIGHT_EVAL: begin
				rd_en   = 1'b1;
				rd_idx  = idx_q + IW'(1);
				advance = right_go && !idx_end;
			end
			sus_pkg::ST_FINISH:      res_valid = 1'b1;
			default:                 items.ready = 1'b0;
		endcase
	end

	assign rd_addr = rd_idx[AW-1:0];
	assign wr_en   = accept && room;
	assign wr_addr = count_q[AW-1:0];
	assign wr_data = items.value;

	// lo may sit at -1 after the left walk, so the length stays in signed width
	assign span_s   = hi_q - lo_q - IW'(1);
	assign span_ext = LW'(span_s[CW-1:0]);
	assign res.span_length = zero_q ? '0 : span_ext[sus_pkg::SPAN_W-1:0];
	assign res.overflow    = ovf_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= sus_pkg::ST_LOAD;
			count_q   <= '0;
			dropped_q <= 1'b0;
			first_q   <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (accept) begin
				if (items.last) begin
					count_q   <= '0;
					dropped_q <= 1'b0;
				end else begin
					count_q   <= n_new;
					dropped_q <= dropped_q || !room;
				end
			end
			if (advance) begin
				first_q <= state_q inside {sus_pkg::ST_PRE_ISSUE, sus_pkg::ST_SUF_ISSUE,
				                           sus_pkg::ST_MM_ISSUE};
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (advance) begin
			idx_q <= rd_idx;
		end
		case (state_q)
			sus_pkg::ST_LOAD: begin
				if (accept && items.last) begin
					n_q    <= n_new;
					ovf_q  <= dropped_q || !room;
					zero_q <= (n_new <= CW'(1));
				end
			end
			sus_pkg::ST_PRE_EVAL: begin
				prev_q <= rd_data;
				if (pre_brk) begin
					lo_q <= idx_q - IW'(1);
				end else if (!first_q && idx_end) begin
					zero_q <= 1'b1;
				end
			end
			sus_pkg::ST_SUF_EVAL: begin
				prev_q <= rd_data;
				if (suf_brk) begin
					hi_q <= idx_q + IW'(1);
				end else if (idx_first) begin
					hi_q <= idx_q;
				end
			end
			sus_pkg::ST_MM_EVAL: begin
				if (first_q || rd_data < vmin_q) begin
					vmin_q <= rd_data;
				end
				if (first_q || rd_data > vmax_q) begin
					vmax_q <= rd_data;
				end
			end
			sus_pkg::ST_LEFT_EVAL: begin
				if (!left_go) begin
					lo_q <= idx_q;
				end else if (idx_first) begin
					lo_q <= idx_q - IW'(1);
				end
			end
			sus_pkg::ST_RIGHT_EVAL: begin
				if (!right_go) begin
					hi_q <= idx_q;
				end else if (idx_end) begin
					hi_q <= n_s;
				end
			end
			default: begin
			end
		endcase
	end

endmodule
`default_nettype wire
